@@ rtl/plrd_pkg.sv @@
// shared types, codes and scaling constants of the press line rupture detector
`timescale 1ns / 1ps

package plrd_pkg;

    localparam int FRAC_DIGITS = 3;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PARSE_SCALE     = 2'd0,
        CFG_START_THRESHOLD = 2'd1,
        CFG_DROP_FRACTION   = 2'd2,
        CFG_STRESS_GAIN     = 2'd3
    } cfg_idx_t;

    localparam logic [23:0] PARSE_SCALE_RST     = 24'd65536;
    localparam logic [30:0] START_THRESHOLD_RST = 31'd100;
    localparam logic [15:0] DROP_FRACTION_RST   = 16'd32768;
    localparam logic [31:0] STRESS_GAIN_RST     = 32'd2136150;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        EV_START   = 2'd0,
        EV_SAMPLE  = 2'd1,
        EV_RUPTURE = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        SCAN_SEEK   = 2'd0,
        SCAN_NUMBER = 2'd1,
        SCAN_DONE   = 2'd2
    } scan_phase_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_POW,
        BK_MUL,
        BK_RND,
        BK_DIV,
        BK_SAT,
        BK_DEC,
        BK_CMP,
        BK_CHK,
        BK_START_OUT,
        BK_SAMPLE_MUL,
        BK_SAMPLE_OUT,
        BK_RUPTURE_MUL,
        BK_RUPTURE_OUT
    } back_state_t;

    typedef struct packed {
        logic        tick;
        logic        negative;
        logic [1:0]  frac_digits;
        logic [31:0] mantissa;
    } job_t;

    typedef struct packed {
        logic [23:0] parse_scale;
        logic [30:0] start_threshold;
        logic [15:0] drop_fraction;
        logic [31:0] stress_gain;
    } cfg_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // load = (m * scale * SCALE_MUL + RND_ADD) >> 16, then / 10 with three fraction digits
    localparam logic [6:0]  SCALE_MUL = (FRAC_DIGITS == 0) ? 7'd100 :
                                        (FRAC_DIGITS == 1) ? 7'd10 : 7'd1;
    localparam logic [19:0] RND_ADD   = (FRAC_DIGITS == 3) ? 20'd327680 : 20'd32768;
    localparam logic        NEED_DIV  = (FRAC_DIGITS == 3);

    localparam int Y_W = 48;

    // divide by ten as a reciprocal multiply on a 35-bit operand, low and high half in turn
    localparam int          DIVIN_W     = 35;
    localparam int          DIV_LO_W    = 18;
    localparam int          RECIP_SHIFT = 38;
    localparam logic [34:0] RECIP_TEN   = 35'd27487790695;
    localparam int          DIV_CYCLES  = 2;
    localparam int          DIV_CNT_W   = $clog2(DIV_CYCLES);

    function automatic logic [9:0] pow10(input logic [1:0] k);
        logic [9:0] r;
        case (k)
            2'd0:    r = 10'd1;
            2'd1:    r = 10'd10;
            2'd2:    r = 10'd100;
            default: r = 10'd1000;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/plrd_front.sv @@
// front end: accepts items, scans line characters and queues ticks and line ends
`timescale 1ns / 1ps

module plrd_front #(
    parameter int MAX_LINE = 120
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_cmd,
    input  logic [7:0]      s_data_byte,
    input  logic            q_full,
    output logic            q_push,
    output plrd_pkg::job_t  q_wdata
);
    import plrd_pkg::*;

    localparam int LEN_W = $clog2(MAX_LINE + 1);

    logic [LEN_W-1:0] line_len_reg, line_len_next;
    scan_phase_t      phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic             seen_point_reg, seen_point_next;
    logic [1:0]       frac_reg, frac_next;
    logic [31:0]      mant_reg, mant_next;

    logic        accept;
    logic        is_eol;
    logic        is_digit;
    logic        is_sign;
    logic        is_point;
    logic [3:0]  digit_val;
    logic [35:0] mant_wide;
    logic [31:0] mant_add;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign is_eol   = (s_data_byte == CHAR_CR) || (s_data_byte == CHAR_LF);
    assign is_digit = (s_data_byte >= CHAR_ZERO) && (s_data_byte <= CHAR_NINE);
    assign is_sign  = (s_data_byte == CHAR_PLUS) || (s_data_byte == CHAR_MINUS);
    assign is_point = (s_data_byte == CHAR_POINT);

    assign digit_val = 4'(s_data_byte - CHAR_ZERO);
    assign mant_wide = 36'(mant_reg) * 36'd10 + 36'(digit_val);
    assign mant_add  = (|mant_wide[35:32]) ? 32'hFFFF_FFFF : mant_wide[31:0];

    assign q_push = accept && ((s_cmd == CMD_TICK) ||
                    (is_eol && (line_len_reg != '0) && (phase_reg != SCAN_SEEK)));

    always_comb begin
        q_wdata.tick        = (s_cmd == CMD_TICK);
        q_wdata.negative    = neg_reg;
        q_wdata.frac_digits = frac_reg;
        q_wdata.mantissa    = mant_reg;
    end

    always_comb begin
        line_len_next   = line_len_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        seen_point_next = seen_point_reg;
        frac_next       = frac_reg;
        mant_next       = mant_reg;
        if (accept && (s_cmd == CMD_BYTE)) begin
            if (is_eol) begin
                line_len_next   = '0;
                phase_next      = SCAN_SEEK;
                neg_next        = 1'b0;
                seen_point_next = 1'b0;
                frac_next       = 2'd0;
                mant_next       = 32'd0;
            end else if (line_len_reg < LEN_W'(MAX_LINE)) begin
                line_len_next = line_len_reg + 1'b1;
                if (phase_reg == SCAN_SEEK && is_sign) begin
                    phase_next = SCAN_NUMBER;
                    neg_next   = (s_data_byte == CHAR_MINUS);
                end else if ((phase_reg == SCAN_SEEK && (is_digit || is_point)) ||
                             phase_reg == SCAN_NUMBER) begin
                    phase_next = SCAN_NUMBER;
                    if (is_digit) begin
                        if (!seen_point_reg) begin
                            mant_next = mant_add;
                        end else if (frac_reg < 2'(FRAC_DIGITS)) begin
                            mant_next = mant_add;
                            frac_next = frac_reg + 2'd1;
                        end
                    end else if (is_point && !seen_point_reg) begin
                        seen_point_next = 1'b1;
                    end else begin
                        phase_next = SCAN_DONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg   <= '0;
            phase_reg      <= SCAN_SEEK;
            neg_reg        <= 1'b0;
            seen_point_reg <= 1'b0;
            frac_reg       <= 2'd0;
            mant_reg       <= 32'd0;
        end else begin
            line_len_reg   <= line_len_next;
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            seen_point_reg <= seen_point_next;
            frac_reg       <= frac_next;
            mant_reg       <= mant_next;
        end
    end

endmodule

@@ rtl/plrd_queue.sv @@
// short job queue between the front end and the arithmetic back end
`timescale 1ns / 1ps

module plrd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  plrd_pkg::job_t  wdata,
    output logic            full,
    output logic            valid,
    output plrd_pkg::job_t  rdata,
    input  logic            pop
);
    import plrd_pkg::*;

    job_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign rdata   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/plrd_back.sv @@
// back end: load scaling, test tracking, stress and the result register
`timescale 1ns / 1ps

module plrd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  plrd_pkg::cfg_t        cfg,
    input  logic                  q_valid,
    input  plrd_pkg::job_t        q_job,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_event_res,
    output logic signed [31:0]    m_load_centi_kn,
    output logic signed [31:0]    m_stress_centi_mpa,
    output logic [31:0]           m_elapsed_ms,
    output logic                  m_last
);
    import plrd_pkg::*;

    function automatic logic [31:0] sat_signed(input logic neg, input logic [Y_W-1:0] mag);
        logic [31:0] r;
        if (neg) begin
            r = (mag >= Y_W'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'd0 - mag[31:0];
        end else begin
            r = (mag > Y_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return r;
    endfunction

    back_state_t          state_reg, state_next;
    logic                 in_test_reg, in_test_next;
    logic [31:0]          peak_reg, peak_next;
    logic [31:0]          elapsed_reg, elapsed_next;
    logic                 start_reg, start_next;
    logic                 rupture_reg, rupture_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 neg_reg, neg_next;
    logic [1:0]           frac_reg, frac_next;
    logic [31:0]          mant_reg, mant_next;
    logic [31:0]          msat_reg, msat_next;
    logic [55:0]          prod_reg, prod_next;
    logic [DIVIN_W-1:0]   y_reg, y_next;
    logic [52:0]          plo_reg, plo_next;
    logic [52:0]          phi_reg, phi_next;
    logic [31:0]          load_reg, load_next;
    logic [46:0]          peakdrop_reg, peakdrop_next;
    logic [63:0]          sprod_reg, sprod_next;
    event_t               out_event_reg, out_event_next;
    logic [31:0]          out_load_reg, out_load_next;
    logic [31:0]          out_stress_reg, out_stress_next;
    logic [31:0]          out_elapsed_reg, out_elapsed_next;
    logic                 out_last_reg, out_last_next;

    logic                 slot_free;
    logic [41:0]          pow_prod;
    logic [63:0]          rnd_sum;
    logic [DIV_LO_W-1:0]  recip_op;
    logic [52:0]          recip_prod;
    logic [70:0]          recip_sum;
    logic [31:0]          quot;
    logic [31:0]          load_abs;
    logic [31:0]          stress_src;
    logic [64:0]          stress_sum;
    logic                 stress_neg;
    logic [31:0]          stress_val;
    logic                 start_hit;
    logic [31:0]          peak_base;

    assign slot_free  = !out_valid_reg || m_ready;
    assign pow_prod   = 42'(mant_reg) * 42'(pow10(2'(FRAC_DIGITS) - frac_reg));
    assign rnd_sum    = 64'(prod_reg) * 64'(SCALE_MUL) + 64'(RND_ADD);
    assign recip_op   = (div_cnt_reg == '0) ? y_reg[DIV_LO_W-1:0]
                                            : DIV_LO_W'(y_reg[DIVIN_W-1:DIV_LO_W]);
    assign recip_prod = 53'(recip_op) * 53'(RECIP_TEN);
    assign recip_sum  = {phi_reg, {DIV_LO_W{1'b0}}} + 71'(plo_reg);
    assign quot       = recip_sum[RECIP_SHIFT+31:RECIP_SHIFT];
    assign load_abs   = load_reg[31] ? 32'd0 - load_reg : load_reg;
    assign stress_src = (state_reg == BK_RUPTURE_MUL) ? peak_reg : load_abs;
    assign stress_sum = {1'b0, sprod_reg} + 65'd8388608;
    assign stress_neg = (state_reg == BK_SAMPLE_OUT) && load_reg[31];
    assign stress_val = sat_signed(stress_neg, Y_W'(stress_sum[64:24]));
    assign start_hit  = !in_test_reg &&
                        ($signed(load_reg) > $signed({1'b0, cfg.start_threshold}));
    assign peak_base  = start_hit ? 32'd0 : peak_reg;

    always_comb begin
        state_next       = state_reg;
        in_test_next     = in_test_reg;
        peak_next        = peak_reg;
        elapsed_next     = elapsed_reg;
        start_next       = start_reg;
        rupture_next     = rupture_reg;
        div_cnt_next     = div_cnt_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        neg_next         = neg_reg;
        frac_next        = frac_reg;
        mant_next        = mant_reg;
        msat_next        = msat_reg;
        prod_next        = prod_reg;
        y_next           = y_reg;
        plo_next         = plo_reg;
        phi_next         = phi_reg;
        load_next        = load_reg;
        peakdrop_next    = peakdrop_reg;
        sprod_next       = sprod_reg;
        out_event_next   = out_event_reg;
        out_load_next    = out_load_reg;
        out_stress_next  = out_stress_reg;
        out_elapsed_next = out_elapsed_reg;
        out_last_next    = out_last_reg;
        q_pop            = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_job.tick) begin
                        elapsed_next = elapsed_reg + 32'd1;
                    end else begin
                        neg_next   = q_job.negative;
                        frac_next  = q_job.frac_digits;
                        mant_next  = q_job.mantissa;
                        state_next = BK_POW;
                    end
                end
            end
            BK_POW: begin
                msat_next  = (|pow_prod[41:32]) ? 32'hFFFF_FFFF : pow_prod[31:0];
                state_next = BK_MUL;
            end
            BK_MUL: begin
                prod_next  = 56'(msat_reg) * 56'(cfg.parse_scale);
                state_next = BK_RND;
            end
            BK_RND: begin
                // values this large saturate either way
                y_next       = (|rnd_sum[63:DIVIN_W+16]) ? {DIVIN_W{1'b1}}
                                                          : rnd_sum[DIVIN_W+15:16];
                div_cnt_next = '0;
                state_next   = NEED_DIV ? BK_DIV : BK_SAT;
            end
            BK_DIV: begin
                if (div_cnt_reg == '0) begin
                    plo_next = recip_prod;
                end else begin
                    phi_next = recip_prod;
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    state_next = BK_SAT;
                end
            end
            BK_SAT: begin
                load_next  = sat_signed(neg_reg, NEED_DIV ? Y_W'(quot) : Y_W'(y_reg));
                state_next = BK_DEC;
            end
            BK_DEC: begin
                start_next = start_hit;
                if (start_hit) begin
                    in_test_next = 1'b1;
                    elapsed_next = 32'd0;
                end
                if (in_test_reg || start_hit) begin
                    peak_next = ($signed(load_reg) > $signed(peak_base)) ? load_reg : peak_base;
                end
                state_next = BK_CMP;
            end
            BK_CMP: begin
                peakdrop_next = 47'(peak_reg[30:0]) * 47'(cfg.drop_fraction);
                state_next    = BK_CHK;
            end
            BK_CHK: begin
                rupture_next = ($signed(peak_reg) > $signed({1'b0, cfg.start_threshold})) &&
                               ($signed({load_reg, 16'd0}) < $signed({1'b0, peakdrop_reg}));
                if (!in_test_reg) begin
                    state_next = BK_IDLE;
                end else if (start_reg) begin
                    state_next = BK_START_OUT;
                end else begin
                    state_next = BK_SAMPLE_MUL;
                end
            end
            BK_START_OUT: begin
                if (slot_free) begin
                    out_valid_next   = 1'b1;
                    out_event_next   = EV_START;
                    out_load_next    = 32'd0;
                    out_stress_next  = 32'd0;
                    out_elapsed_next = 32'd0;
                    out_last_next    = 1'b0;
                    state_next       = BK_SAMPLE_MUL;
                end
            end
            BK_SAMPLE_MUL: begin
                sprod_next = 64'(stress_src) * 64'(cfg.stress_gain);
                state_next = BK_SAMPLE_OUT;
            end
            BK_SAMPLE_OUT: begin
                if (slot_free) begin
                    out_valid_next   = 1'b1;
                    out_event_next   = EV_SAMPLE;
                    out_load_next    = load_reg;
                    out_stress_next  = stress_val;
                    out_elapsed_next = elapsed_reg;
                    out_last_next    = !rupture_reg;
                    state_next       = rupture_reg ? BK_RUPTURE_MUL : BK_IDLE;
                end
            end
            BK_RUPTURE_MUL: begin
                sprod_next = 64'(stress_src) * 64'(cfg.stress_gain);
                state_next = BK_RUPTURE_OUT;
            end
            BK_RUPTURE_OUT: begin
                if (slot_free) begin
                    out_valid_next   = 1'b1;
                    out_event_next   = EV_RUPTURE;
                    out_load_next    = peak_reg;
                    out_stress_next  = stress_val;
                    out_elapsed_next = elapsed_reg;
                    out_last_next    = 1'b1;
                    in_test_next     = 1'b0;
                    peak_next        = 32'd0;
                    state_next       = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            in_test_reg   <= 1'b0;
            peak_reg      <= 32'd0;
            elapsed_reg   <= 32'd0;
            start_reg     <= 1'b0;
            rupture_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_test_reg   <= in_test_next;
            peak_reg      <= peak_next;
            elapsed_reg   <= elapsed_next;
            start_reg     <= start_next;
            rupture_reg   <= rupture_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg         <= neg_next;
        frac_reg        <= frac_next;
        mant_reg        <= mant_next;
        msat_reg        <= msat_next;
        prod_reg        <= prod_next;
        y_reg           <= y_next;
        plo_reg         <= plo_next;
        phi_reg         <= phi_next;
        load_reg        <= load_next;
        peakdrop_reg    <= peakdrop_next;
        sprod_reg       <= sprod_next;
        out_event_reg   <= out_event_next;
        out_load_reg    <= out_load_next;
        out_stress_reg  <= out_stress_next;
        out_elapsed_reg <= out_elapsed_next;
        out_last_reg    <= out_last_next;
    end

    assign m_valid            = out_valid_reg;
    assign m_event_res        = out_event_reg;
    assign m_load_centi_kn    = out_load_reg;
    assign m_stress_centi_mpa = out_stress_reg;
    assign m_elapsed_ms       = out_elapsed_reg;
    assign m_last             = out_last_reg;

endmodule

@@ rtl/press_line_rupture_detector_unit.sv @@
// top level of the press line rupture detector: register file, front end, queue, back end
`timescale 1ns / 1ps

// Serial bytes and millisecond ticks enter on the s_ channel; test start, sample and
// rupture results leave on the m_ channel, with m_last on the final result of a line.
// The scanner takes each item in the cycle it is accepted. Ticks and line ends holding
// a number pass through a four-entry queue to the back end; there a tick counts time and
// a line end runs registered multiplies, a reciprocal divide by ten and the start and
// drop checks, then gives its results, each waiting while m_ready holds one back. Input
// of any kind stalls only when that queue is full. Configuration registers are written
// through cfg_we, cfg_index and cfg_wdata while the block is idle: a rule for the user,
// which the block itself does not enforce.
module press_line_rupture_detector_unit #(
    parameter int MAX_LINE = 120
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [7:0]                     s_data_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_event_res,
    output logic signed [31:0]             m_load_centi_kn,
    output logic signed [31:0]             m_stress_centi_mpa,
    output logic [31:0]                    m_elapsed_ms,
    output logic                           m_last,
    input  logic                           cfg_we,
    input  logic [plrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plrd_pkg::CFG_W-1:0]     cfg_wdata
);
    import plrd_pkg::*;

    cfg_t cfg_reg, cfg_next;
    job_t q_wdata;
    job_t q_rdata;
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_PARSE_SCALE:     cfg_next.parse_scale     = cfg_wdata[23:0];
                CFG_START_THRESHOLD: cfg_next.start_threshold = cfg_wdata[30:0];
                CFG_DROP_FRACTION:   cfg_next.drop_fraction   = cfg_wdata[15:0];
                CFG_STRESS_GAIN:     cfg_next.stress_gain     = cfg_wdata[31:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.parse_scale     <= PARSE_SCALE_RST;
            cfg_reg.start_threshold <= START_THRESHOLD_RST;
            cfg_reg.drop_fraction   <= DROP_FRACTION_RST;
            cfg_reg.stress_gain     <= STRESS_GAIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    plrd_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    plrd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .valid   (q_valid),
        .rdata   (q_rdata),
        .pop     (q_pop)
    );

    plrd_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .q_valid            (q_valid),
        .q_job              (q_rdata),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_res        (m_event_res),
        .m_load_centi_kn    (m_load_centi_kn),
        .m_stress_centi_mpa (m_stress_centi_mpa),
        .m_elapsed_ms       (m_elapsed_ms),
        .m_last             (m_last)
    );

`ifndef ASSERT_OFF
    a_rupture_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_RUPTURE) |-> m_last)
        else $error("rupture item without last");

    a_start_is_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_START) |->
            (!m_last && m_load_centi_kn == 32'sd0 && m_elapsed_ms == 32'd0))
        else $error("start item not blank or marked last");

    a_stress_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_SAMPLE && m_load_centi_kn[31]) |->
            (m_stress_centi_mpa[31] || m_stress_centi_mpa == 32'sd0))
        else $error("stress sign differs from load sign");

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("job pushed into full queue");
`endif

endmodule
